>>> sv/lfp_pkg.sv
// Shared constants, controller/datapath interface types and header decoding for the frame parser.
package lfp_pkg;

    localparam int MAX_PAYLOAD = 64;
    localparam int HDR_LEN     = 3;
    localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);
    localparam int ADDR_W      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int POS_W       = LEN_W;

    localparam logic [7:0] START_CHAR   = 8'h53;
    localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
    localparam logic [7:0] PLUS_CHAR    = 8'h2B;
    localparam logic [7:0] MINUS_CHAR   = 8'h2D;
    localparam logic [7:0] ZERO_CHAR    = 8'h30;
    localparam logic [7:0] NINE_CHAR    = 8'h39;
    localparam logic [7:0] SPACE_CHAR   = 8'h20;
    localparam logic [7:0] TAB_CHAR     = 8'h09;
    localparam logic [7:0] CR_CHAR      = 8'h0D;

    localparam logic EVENT_PAYLOAD = 1'b0;
    localparam logic EVENT_CANCEL  = 1'b1;

    typedef struct packed {
        logic wp_clr;
        logic hdr_wr;
        logic len_load;
        logic pay_wr;
        logic dump_start;
        logic dump_adv;
        logic emit_cancel;
    } lfp_cmd_t;

    typedef struct packed {
        logic is_nl;
        logic is_start;
        logic hdr_done;
        logic hdr_ok;
        logic pay_done;
        logic dump_last;
        logic out_free;
    } lfp_stat_t;

    // Returns the payload length, or zero when the header cancels the frame.
    function automatic logic [LEN_W-1:0] decode_header(input logic [7:0] c0,
                                                       input logic [7:0] c1,
                                                       input logic [7:0] c2);
        logic [7:0] ch [HDR_LEN];
        logic [1:0] st;
        logic       neg;
        logic [9:0] mag;
        logic [3:0] dig;
        logic       blank;
        logic       digit;
        ch[0] = c0;
        ch[1] = c1;
        ch[2] = c2;
        st    = 2'd0;
        neg   = 1'b0;
        mag   = '0;
        for (int k = 0; k < HDR_LEN; k++) begin
            blank = (ch[k] == SPACE_CHAR) || (ch[k] >= TAB_CHAR && ch[k] <= CR_CHAR);
            digit = (ch[k] >= ZERO_CHAR) && (ch[k] <= NINE_CHAR);
            dig   = 4'(ch[k] - ZERO_CHAR);
            if (st == 2'd0) begin
                if (blank) begin
                    st = 2'd0;
                end else if (ch[k] == PLUS_CHAR || ch[k] == MINUS_CHAR) begin
                    neg = (ch[k] == MINUS_CHAR);
                    st  = 2'd1;
                end else if (digit) begin
                    mag = 10'(dig);
                    st  = 2'd1;
                end else begin
                    st = 2'd2;
                end
            end else if (st == 2'd1) begin
                if (digit) begin
                    mag = 10'((mag << 3) + (mag << 1) + 10'(dig));
                end else begin
                    st = 2'd2;
                end
            end
        end
        if (neg || mag == '0 || mag > 10'(MAX_PAYLOAD)) begin
            return '0;
        end
        return LEN_W'(mag);
    endfunction

endpackage

>>> sv/lfp_datapath.sv
// Datapath of the frame parser: header registers, payload memory, counters and result register.
module lfp_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        rx_byte,
    input  lfp_pkg::lfp_cmd_t cmd,
    output lfp_pkg::lfp_stat_t stat,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              event_kind,
    output logic [7:0]        payload_byte,
    output logic              last_flag
);
    import lfp_pkg::*;

    logic [POS_W-1:0]  wp_reg, wp_next;
    logic [LEN_W-1:0]  len_reg;
    logic [7:0]        hdr0_reg, hdr1_reg;
    logic [ADDR_W-1:0] rd_addr_reg, rd_addr_next;
    logic [7:0]        mem [MAX_PAYLOAD];
    logic [7:0]        mem_q;
    logic [LEN_W-1:0]  dec_len;
    logic              out_valid_reg, out_valid_next;
    logic              kind_reg;
    logic [7:0]        byte_reg;
    logic              last_reg;
    logic              out_free;

    assign dec_len  = decode_header(hdr0_reg, hdr1_reg, rx_byte);
    assign out_free = !out_valid_reg || out_ready;

    assign stat.is_nl     = (rx_byte == NEWLINE_CHAR);
    assign stat.is_start  = (rx_byte == START_CHAR);
    assign stat.hdr_done  = (wp_reg == POS_W'(HDR_LEN - 1));
    assign stat.hdr_ok    = (dec_len != '0);
    assign stat.pay_done  = (POS_W'(wp_reg + 1'b1) == POS_W'(len_reg));
    assign stat.dump_last = (POS_W'({1'b0, rd_addr_reg} + 1'b1) == wp_reg);
    assign stat.out_free  = out_free;

    always_comb
    begin
        wp_next = wp_reg;
        if (cmd.wp_clr) begin
            wp_next = '0;
        end else if (cmd.hdr_wr || cmd.pay_wr) begin
            wp_next = POS_W'(wp_reg + 1'b1);
        end
        rd_addr_next = rd_addr_reg;
        if (cmd.dump_start) begin
            rd_addr_next = '0;
        end else if (cmd.dump_adv) begin
            rd_addr_next = ADDR_W'(rd_addr_reg + 1'b1);
        end
        out_valid_next = out_valid_reg;
        if (cmd.emit_cancel || cmd.dump_adv) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            wp_reg        <= wp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_addr_reg <= rd_addr_next;
        if (cmd.hdr_wr && wp_reg == '0) begin
            hdr0_reg <= rx_byte;
        end
        if (cmd.hdr_wr && wp_reg == POS_W'(1)) begin
            hdr1_reg <= rx_byte;
        end
        if (cmd.len_load) begin
            len_reg <= dec_len;
        end
        if (cmd.emit_cancel) begin
            kind_reg <= EVENT_CANCEL;
            byte_reg <= '0;
            last_reg <= 1'b1;
        end else if (cmd.dump_adv) begin
            kind_reg <= EVENT_PAYLOAD;
            byte_reg <= mem_q;
            last_reg <= stat.dump_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pay_wr) begin
            mem[wp_reg[ADDR_W-1:0]] <= rx_byte;
        end
        mem_q <= mem[rd_addr_next];
    end

    assign out_valid    = out_valid_reg;
    assign event_kind   = kind_reg;
    assign payload_byte = byte_reg;
    assign last_flag    = last_reg;

endmodule

>>> sv/lfp_ctrl.sv
// Controller state machine of the frame parser.
module lfp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  lfp_pkg::lfp_stat_t stat,
    output lfp_pkg::lfp_cmd_t  cmd
);
    import lfp_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEADER,
        ST_PAYLOAD,
        ST_TERM,
        ST_DUMP
    } state_t;

    state_t state_reg, state_next;
    logic   take;

    assign in_ready = (state_reg != ST_DUMP) && stat.out_free;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (take) begin
                    cmd.wp_clr = 1'b1;
                    if (stat.is_start) begin
                        state_next = ST_HEADER;
                    end
                end
            end
            ST_HEADER:
            begin
                if (take) begin
                    if (stat.is_nl) begin
                        cmd.wp_clr = 1'b1;
                        state_next = ST_IDLE;
                    end else if (stat.hdr_done) begin
                        cmd.wp_clr = 1'b1;
                        if (stat.hdr_ok) begin
                            cmd.len_load = 1'b1;
                            state_next   = ST_PAYLOAD;
                        end else begin
                            cmd.emit_cancel = 1'b1;
                            state_next      = ST_IDLE;
                        end
                    end else begin
                        cmd.hdr_wr = 1'b1;
                    end
                end
            end
            ST_PAYLOAD:
            begin
                if (take) begin
                    if (stat.is_nl) begin
                        cmd.wp_clr      = 1'b1;
                        cmd.emit_cancel = 1'b1;
                        state_next      = ST_IDLE;
                    end else begin
                        cmd.pay_wr = 1'b1;
                        if (stat.pay_done) begin
                            state_next = ST_TERM;
                        end
                    end
                end
            end
            ST_TERM:
            begin
                if (take) begin
                    if (stat.is_nl) begin
                        cmd.dump_start = 1'b1;
                        state_next     = ST_DUMP;
                    end else begin
                        cmd.wp_clr      = 1'b1;
                        cmd.emit_cancel = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end
            end
            ST_DUMP:
            begin
                if (stat.out_free) begin
                    cmd.dump_adv = 1'b1;
                    if (stat.dump_last) begin
                        cmd.wp_clr = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> sv/length_prefixed_frame_parser_top.sv
// Top level of the length-prefixed frame parser.
// The parser takes one received byte per cycle and frames messages made of 'S', a three-character
// decimal header, that many payload bytes (1 to 64) and a newline; a bad header, a newline in the
// payload or a wrong terminator gives one cancel beat (a newline inside the header drops the
// frame with no beat); a complete frame gives its payload as a run of beats with last_flag set
// on the final one. Input is taken at one beat per clock while a frame is parsed, except that it
// waits while a result sits in the output register and the output side does not take it. After
// the terminator the input stalls while a run of N bytes is read out of the payload memory, one
// beat per cycle; the read of the first byte overlaps the terminator cycle, so the first beat
// enters the output register with no stall before it. Stalls on the output side lengthen the run.
module length_prefixed_frame_parser_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       event_kind,
    output logic [7:0] payload_byte,
    output logic       last_flag
);
    import lfp_pkg::*;

    lfp_cmd_t  cmd;
    lfp_stat_t stat;

    lfp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lfp_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .rx_byte      (rx_byte),
        .cmd          (cmd),
        .stat         (stat),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .event_kind   (event_kind),
        .payload_byte (payload_byte),
        .last_flag    (last_flag)
    );

endmodule
